### rtl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_SIZE = 13;
    localparam int KEY_WIDTH  = 16;
    localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int TSIZE_W    = $clog2(TABLE_SIZE + 1);

    // floor(2^KEY_WIDTH / TABLE_SIZE), used for the home slot reduction
    localparam logic [KEY_WIDTH-1:0] HASH_RECIP =
        KEY_WIDTH'((64'd1 << KEY_WIDTH) / 64'(TABLE_SIZE));

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [KEY_WIDTH-1:0] key;
        logic [SLOT_W-1:0]    home;
    } cmd_t;

endpackage

### rtl/lpht_front.sv
`timescale 1ns / 1ps

module lpht_front
    import lpht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic [KEY_WIDTH-1:0] key,
    output logic                 cmd_push,
    output cmd_t                 cmd,
    input  logic                 cmd_full
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [1:0]                  s1_op_reg;
    logic [KEY_WIDTH-1:0]        s1_key_reg;
    logic [KEY_WIDTH-1:0]        s1_quot_reg;
    logic [KEY_WIDTH-1:0]        quot_next;
    logic [2*KEY_WIDTH-1:0]      recip_prod;
    logic [KEY_WIDTH+TSIZE_W-1:0] back_prod;
    logic [KEY_WIDTH+TSIZE_W-1:0] rem_wide;
    logic [SLOT_W:0]             rem_est;
    logic [SLOT_W:0]             rem_fix;
    logic                        accept;

    assign accept   = push && !full;
    assign full     = s1_valid_reg && cmd_full;
    assign cmd_push = s1_valid_reg && !cmd_full;

    // quotient estimate is low by at most one
    assign recip_prod = (2*KEY_WIDTH)'(key) * (2*KEY_WIDTH)'(HASH_RECIP);
    assign quot_next  = recip_prod[2*KEY_WIDTH-1:KEY_WIDTH];

    assign back_prod = (KEY_WIDTH+TSIZE_W)'(s1_quot_reg)
                     * (KEY_WIDTH+TSIZE_W)'(TABLE_SIZE);
    assign rem_wide  = (KEY_WIDTH+TSIZE_W)'(s1_key_reg) - back_prod;
    assign rem_est   = rem_wide[SLOT_W:0];
    assign rem_fix   = (rem_est >= (SLOT_W+1)'(TABLE_SIZE))
                     ? rem_est - (SLOT_W+1)'(TABLE_SIZE) : rem_est;

    assign cmd.op   = s1_op_reg;
    assign cmd.key  = s1_key_reg;
    assign cmd.home = rem_fix[SLOT_W-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (cmd_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode;
            s1_key_reg  <= key;
            s1_quot_reg <= quot_next;
        end
    end

endmodule

### rtl/lpht_cmd_fifo.sv
`timescale 1ns / 1ps

module lpht_cmd_fifo
    import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_push,
    input  cmd_t wr_cmd,
    output logic wr_full,
    input  logic rd_pop,
    output cmd_t rd_cmd,
    output logic rd_empty
);

    cmd_t                 entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg;
    logic [CMD_PTR_W:0]   count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_full  = (count_reg == (CMD_PTR_W+1)'(CMD_FIFO_DEPTH));
    assign rd_empty = (count_reg == '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_push && !wr_full;
    assign do_rd    = rd_pop && !rd_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (CMD_PTR_W+1)'(CMD_FIFO_DEPTH))
        else $error("command queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_full |-> !wr_push)
        else $error("front pushed into a full command queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue count did not follow a write");

endmodule

### rtl/lpht_back.sv
`timescale 1ns / 1ps

module lpht_back
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot_index
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [1:0]              op_reg;
    logic [1:0]              op_next;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [KEY_WIDTH-1:0]    key_next;
    logic [SLOT_W-1:0]       addr_reg;
    logic [SLOT_W-1:0]       addr_next;
    logic [SLOT_W-1:0]       probe_cnt_reg;
    logic [SLOT_W-1:0]       probe_cnt_next;
    logic [TABLE_SIZE-1:0]   valid_reg;
    logic [TABLE_SIZE-1:0]   valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [1:0]              out_status_reg;
    logic [1:0]              out_status_next;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [SLOT_W-1:0]       out_slot_next;

    logic [KEY_WIDTH-1:0]    slot_keys_mem [TABLE_SIZE];
    logic [KEY_WIDTH-1:0]    key_rd_reg;

    logic                    out_free;
    logic [SLOT_W-1:0]       addr_inc;
    logic                    cur_valid;
    logic                    key_match;
    logic                    last_probe;
    logic                    probe_stop;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    mem_we;

    assign out_free   = !out_valid_reg || pop;
    assign addr_inc   = (addr_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : addr_reg + 1'b1;
    assign cur_valid  = valid_reg[addr_reg];
    assign key_match  = (key_rd_reg == key_reg);
    assign last_probe = (probe_cnt_reg == SLOT_W'(TABLE_SIZE - 1));
    // an empty slot ends both insert and search; a match ends a search
    assign probe_stop = !cur_valid || ((op_reg == OP_SEARCH) && key_match);

    assign empty      = !out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_slot_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        cmd_pop         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_inc;
        mem_we          = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = cmd.home;
                if (!cmd_empty)
                begin
                    if ((cmd.op == OP_INSERT) || (cmd.op == OP_SEARCH))
                    begin
                        cmd_pop        = 1'b1;
                        rd_en          = 1'b1;
                        op_next        = cmd.op;
                        key_next       = cmd.key;
                        addr_next      = cmd.home;
                        probe_cnt_next = '0;
                        state_next     = S_PROBE;
                    end
                    else if (out_free)
                    begin
                        // clear, or an unused opcode that changes nothing
                        cmd_pop         = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = ST_DONE;
                        out_slot_next   = '0;
                        if (cmd.op == OP_CLEAR)
                        begin
                            valid_next = '0;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                if (!(probe_stop || last_probe))
                begin
                    rd_en          = 1'b1;
                    addr_next      = addr_inc;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = '0;
                    state_next     = S_IDLE;
                    if (op_reg == OP_INSERT)
                    begin
                        if (!cur_valid)
                        begin
                            mem_we              = 1'b1;
                            valid_next[addr_reg] = 1'b1;
                            out_status_next     = ST_DONE;
                            out_slot_next       = addr_reg;
                        end
                        else
                        begin
                            out_status_next = ST_FULL;
                        end
                    end
                    else if (cur_valid && key_match)
                    begin
                        out_status_next = ST_FOUND;
                        out_slot_next   = addr_reg;
                    end
                    else
                    begin
                        out_status_next = ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_CLEAR;
            key_reg        <= '0;
            addr_reg       <= '0;
            probe_cnt_reg  <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            addr_reg       <= addr_next;
            probe_cnt_reg  <= probe_cnt_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_keys_mem[addr_reg] <= key_reg;
        end
        if (rd_en)
        begin
            key_rd_reg <= slot_keys_mem[rd_addr];
        end
    end

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |->
            ((addr_reg < SLOT_W'(TABLE_SIZE)) && (probe_cnt_reg < SLOT_W'(TABLE_SIZE))))
        else $error("probe address or count out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=>
            (out_valid_reg && $stable(out_status_reg) && $stable(out_slot_reg)))
        else $error("waiting result overwritten");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !valid_reg[addr_reg])
        else $error("insert wrote over an occupied slot");

endmodule

### rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps

// Open-addressing hash table of TABLE_SIZE key slots with linear probing; the
// home slot is key modulo TABLE_SIZE. The front end registers a request with
// its quotient estimate, then finishes the hash and queues it; the back end
// runs the probe loop. Clear, and any unused opcode, is handled in the back
// end's idle state. Insert and search read the home slot's key through the key
// memory read port, then probe slot after slot, up to TABLE_SIZE slots. Hashing
// overlaps the probe of the previous request. One result comes back per request
// in request order; a finished result waits in an output register while the
// next insert or search request is taken, but a clear or unused opcode waits
// until it is popped. After reset every slot is empty and the block is ready.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic [KEY_WIDTH-1:0] key,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [SLOT_W-1:0]    slot_index
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_push;
    logic fifo_full;
    logic fifo_empty;
    logic back_pop;

    lpht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .opcode   (opcode),
        .key      (key),
        .cmd_push (front_push),
        .cmd      (front_cmd),
        .cmd_full (fifo_full)
    );

    lpht_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_push  (front_push),
        .wr_cmd   (front_cmd),
        .wr_full  (fifo_full),
        .rd_pop   (back_pop),
        .rd_cmd   (back_cmd),
        .rd_empty (fifo_empty)
    );

    lpht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_empty  (fifo_empty),
        .cmd_pop    (back_pop),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .slot_index (slot_index)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpht_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RANDOM_ITEMS   = 1900;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         NUM_DIRECTED   = 27;

    typedef enum int {RX_STREAM, RX_SKIP4, RX_RANDOM, RX_SLOW} rx_mode_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [KEY_WIDTH-1:0] k;
        logic                 typed;
        logic [1:0]           st;
        logic [SLOT_W-1:0]    sl;
    } stim_row_t;

    typedef struct packed {
        logic [1:0]        st;
        logic [SLOT_W-1:0] sl;
        logic [31:0]       seq;
    } lookup_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           opcode = OP_CLEAR;
    logic [KEY_WIDTH-1:0] key = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           status;
    logic [SLOT_W-1:0]    slot_index;

    // shadow copy of the table contents
    logic [KEY_WIDTH-1:0] tbl_key [TABLE_SIZE];
    bit                   tbl_used [TABLE_SIZE];

    lookup_result_t lookup_q [$];
    lookup_result_t head_exp;

    bit       push_on;
    bit       in_random;
    int       burst_left;
    int       gapless_left;
    int       hold_left;
    int       idle_cycles;
    int       rx_tick;
    rx_mode_t rx_mode = RX_STREAM;

    int unsigned sent_count;
    int unsigned random_items;
    int unsigned checked_count;
    int unsigned mismatch_count;
    int unsigned n_clear, n_insert, n_full, n_search, n_found, n_unused, n_drain;

    // directed requests; typed results only where they are obvious
    stim_row_t dir_rows [NUM_DIRECTED] = '{
        '{OP_SEARCH, 16'h0000, 1'b1, ST_NOT_FOUND, 4'd0},
        '{OP_INSERT, 16'h0000, 1'b1, ST_DONE,      4'd0},
        '{OP_INSERT, 16'd13,   1'b1, ST_DONE,      4'd1},
        '{OP_INSERT, 16'd12,   1'b1, ST_DONE,      4'd12},
        '{OP_INSERT, 16'd25,   1'b0, ST_DONE,      4'd0},
        '{OP_SEARCH, 16'd25,   1'b0, ST_DONE,      4'd0},
        '{OP_SEARCH, 16'd38,   1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h0000, 1'b0, ST_DONE,      4'd0},
        '{OP_SEARCH, 16'h0000, 1'b1, ST_FOUND,     4'd0},
        '{OP_UNUSED, 16'hFFFF, 1'b1, ST_DONE,      4'd0},
        '{OP_CLEAR,  16'hFFFF, 1'b1, ST_DONE,      4'd0},
        '{OP_SEARCH, 16'd13,   1'b1, ST_NOT_FOUND, 4'd0},
        '{OP_INSERT, 16'hFFFF, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h8000, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h5555, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'hAAAA, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h7FFF, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h0001, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h1234, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'hFFFF, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h00FF, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'hFF00, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h0F0F, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'hF0F0, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'hC3C3, 1'b0, ST_DONE,      4'd0},
        '{OP_INSERT, 16'h0007, 1'b1, ST_FULL,      4'd0},
        '{OP_SEARCH, 16'hBEEF, 1'b1, ST_NOT_FOUND, 4'd0}
    };

    linear_probe_hash_table i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .key        (key),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .slot_index (slot_index)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic probe_table(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k,
                               output logic [1:0] st, output logic [SLOT_W-1:0] sl);
        int  pos;
        int  n;
        bit  stop;
        pos  = int'(k) % TABLE_SIZE;
        stop = 1'b0;
        st   = ST_DONE;
        sl   = '0;
        case (op)
            OP_CLEAR:
            begin
                for (n = 0; n < TABLE_SIZE; n++)
                    tbl_used[n] = 1'b0;
            end
            OP_INSERT:
            begin
                st = ST_FULL;
                for (n = 0; n < TABLE_SIZE && !stop; n++)
                begin
                    if (!tbl_used[pos])
                    begin
                        tbl_key[pos]  = k;
                        tbl_used[pos] = 1'b1;
                        st   = ST_DONE;
                        sl   = SLOT_W'(pos);
                        stop = 1'b1;
                    end
                    else
                        pos = (pos + 1) % TABLE_SIZE;
                end
            end
            OP_SEARCH:
            begin
                st = ST_NOT_FOUND;
                for (n = 0; n < TABLE_SIZE && !stop; n++)
                begin
                    // no deletes, so an empty slot ends the probe chain
                    if (!tbl_used[pos])
                        stop = 1'b1;
                    else if (tbl_key[pos] == k)
                    begin
                        st   = ST_FOUND;
                        sl   = SLOT_W'(pos);
                        stop = 1'b1;
                    end
                    else
                        pos = (pos + 1) % TABLE_SIZE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic idle_sender(input int cycles);
        if (push_on)
        begin
            push    <= 1'b0;
            push_on  = 1'b0;
        end
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_req(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k,
                            input logic typed, input logic [1:0] t_st,
                            input logic [SLOT_W-1:0] t_sl);
        logic [1:0]        st;
        logic [SLOT_W-1:0] sl;
        lookup_result_t    r;
        int                gap;
        push    <= 1'b1;
        opcode  <= op;
        key     <= k;
        push_on  = 1'b1;
        do
            @(posedge clk);
        while (full);
        probe_table(op, k, st, sl);
        r.st  = typed ? t_st : st;
        r.sl  = typed ? t_sl : sl;
        r.seq = sent_count;
        lookup_q.push_back(r);
        sent_count++;
        if (in_random && op != OP_UNUSED)
            random_items++;
        case (op)
            OP_CLEAR:  n_clear++;
            OP_INSERT:
            begin
                n_insert++;
                if (st == ST_FULL)
                    n_full++;
            end
            OP_SEARCH:
            begin
                n_search++;
                if (st == ST_FOUND)
                    n_found++;
            end
            default:   n_unused++;
        endcase
        // bursts with random gaps; some bursts run back to back
        if (gapless_left > 0)
            gapless_left--;
        else if (burst_left <= 1)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_sender(gap);
        end
        else
            burst_left--;
    endtask

    task automatic drain_pause();
        idle_sender(1);
        wait (lookup_q.size() == 0);
        @(posedge clk);
        n_drain++;
    endtask

    // an optional clear, then inserts and searches around one crowded home slot
    task automatic run_episode();
        int unsigned          home;
        int unsigned          n_items;
        int unsigned          max_mult;
        logic [KEY_WIDTH-1:0] k;
        logic [1:0]           op;
        logic [KEY_WIDTH-1:0] stored [$];
        if ($urandom_range(0, 3) != 0)
            send_req(OP_CLEAR, KEY_WIDTH'($urandom_range(0, 65535)), 1'b0, ST_DONE, '0);
        home     = $urandom_range(0, TABLE_SIZE - 1);
        max_mult = ((2 ** KEY_WIDTH) - 1 - home) / TABLE_SIZE;
        n_items  = $urandom_range(4, 32);
        repeat (n_items)
        begin
            case ($urandom_range(0, 2))
                0:       k = KEY_WIDTH'(home + TABLE_SIZE * $urandom_range(0, max_mult));
                1:       k = KEY_WIDTH'($urandom_range(0, 65535));
                default:
                begin
                    if (stored.size() > 0)
                        k = stored[$urandom_range(0, stored.size() - 1)];
                    else
                        k = KEY_WIDTH'(home + TABLE_SIZE * $urandom_range(0, max_mult));
                end
            endcase
            op = ($urandom_range(0, 9) < 5) ? OP_INSERT : OP_SEARCH;
            if (op == OP_INSERT)
                stored.push_back(k);
            send_req(op, k, 1'b0, ST_DONE, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            checked_count++;
            if (lookup_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d slot %0d with nothing pending",
                             status, slot_index);
                mismatch_count++;
            end
            else
            begin
                head_exp = lookup_q.pop_front();
                if (status !== head_exp.st || slot_index !== head_exp.sl)
                begin
                    if (mismatch_count < 10)
                        $display("request %0d: status exp %0d got %0d, slot exp %0d got %0d",
                                 head_exp.seq, head_exp.st, status, head_exp.sl, slot_index);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: stall pattern is redrawn at random as rx_tick runs, long hold-off on request
    initial begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (rx_tick % 100 == 0)
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_tick++;
                case (rx_mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_SKIP4:  pop <= (rx_tick % 4) != 3;
                    RX_RANDOM: pop <= $urandom_range(0, 2) != 0;
                    default:   pop <= (rx_tick % 7) == 0;
                endcase
            end
        end
    end

    // watchdog on cycles without any request or result moving
    initial begin
        wait (rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        bit pressure_done;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (n = 0; n < NUM_DIRECTED; n++)
            send_req(dir_rows[n].op, dir_rows[n].k, dir_rows[n].typed,
                     dir_rows[n].st, dir_rows[n].sl);
        drain_pause();
        in_random = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            // receiver goes quiet while the sender keeps pushing
            if (!pressure_done && random_items > 600)
            begin
                hold_left     = HOLD_CYCLES;
                gapless_left  = 48;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(2, 10))
                    send_req(2'($urandom_range(0, 3)), KEY_WIDTH'($urandom_range(0, 65535)),
                             1'b0, ST_DONE, '0);
            end
            else
                run_episode();
            if ($urandom_range(0, 7) == 0)
                drain_pause();
        end
        idle_sender(1);
        wait (lookup_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d requests, %0d results checked: %0d clears, %0d unused opcodes",
                 sent_count, checked_count, n_clear, n_unused);
        $display("%0d inserts (%0d into a full table), %0d searches (%0d found), %0d drains",
                 n_insert, n_full, n_search, n_found, n_drain);
        if (mismatch_count == 0 && lookup_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
